>>> design/veg_pkg.sv
// veg_pkg: shared types, codes and constants of the vibration envelope generator.
// Holds the raised-cosine level function used to build the cosine ROM.
// No dependencies.
package veg_pkg;

	// configuration register indexes
	localparam logic [1:0] REG_TYPE    = 2'd0;
	localparam logic [1:0] REG_PARAM_A = 2'd1;
	localparam logic [1:0] REG_PARAM_B = 2'd2;

	// waveform codes
	localparam logic [2:0] WAVE_CONST  = 3'd0;
	localparam logic [2:0] WAVE_PULSE  = 3'd1;
	localparam logic [2:0] WAVE_COS    = 3'd2;
	localparam logic [2:0] WAVE_FADEOUT = 3'd3;
	localparam logic [2:0] WAVE_FADEIN = 3'd4;

	// status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BAD_TYPE = 2'd1;
	localparam logic [1:0] ST_ENDLESS  = 2'd2;
	localparam logic [1:0] ST_ZERO_LEN = 2'd3;

	// output select codes
	localparam logic [2:0] SEL_ZERO  = 3'd0;
	localparam logic [2:0] SEL_FULL  = 3'd1;
	localparam logic [2:0] SEL_COS   = 3'd2;
	localparam logic [2:0] SEL_QUOT  = 3'd3;
	localparam logic [2:0] SEL_PULSE = 3'd4;

	localparam logic [15:0] FULL_Q15 = 16'd32768;
	localparam int PHASE_BITS = 20;
	// the divider numerator holds a fade term (39 bits) or a time of up to 24 bits
	localparam int NUM_W = 40;
	// divisor holds a pulse period (sum of two 24-bit times)
	localparam int DIV_W = 25;

	localparam longint ONE_Q30     = 64'sd1073741824;
	localparam longint TWO_PI_Q30  = 64'sd6746518852;
	localparam longint PI_Q30      = 64'sd3373259426;
	localparam longint HALF_PI_Q30 = 64'sd1686629713;

	typedef struct packed {
		logic [2:0]  sel;
		logic [1:0]  status;
		logic [15:0] level;
	} veg_tag_t;

	// (1 - cos(theta)) / 2 in Q15, theta in Q30 within [0, 2*pi).
	// Degree-14 Taylor series on the folded quadrant; elaboration only.
	function automatic logic [15:0] rc_level(input longint theta);
		longint th;
		logic neg;
		longint unsigned tu;
		longint unsigned x2;
		longint unsigned r;
		longint unsigned tt;
		longint c;
		longint diff;
		longint v;
		th = theta;
		neg = 1'b0;
		if (th > PI_Q30) th = 2 * PI_Q30 - th;
		if (th < 0) th = 0;
		if (th > HALF_PI_Q30) begin
			th = PI_Q30 - th;
			if (th < 0) th = 0;
			neg = 1'b1;
		end
		tu = longint'(th);
		x2 = (tu * tu) >> 30;
		r = ONE_Q30;
		tt = ((x2 * r) >> 30) / 182;
		r = (tt >= ONE_Q30) ? 64'd0 : ONE_Q30 - tt;
		tt = ((x2 * r) >> 30) / 132;
		r = (tt >= ONE_Q30) ? 64'd0 : ONE_Q30 - tt;
		tt = ((x2 * r) >> 30) / 90;
		r = (tt >= ONE_Q30) ? 64'd0 : ONE_Q30 - tt;
		tt = ((x2 * r) >> 30) / 56;
		r = (tt >= ONE_Q30) ? 64'd0 : ONE_Q30 - tt;
		tt = ((x2 * r) >> 30) / 30;
		r = (tt >= ONE_Q30) ? 64'd0 : ONE_Q30 - tt;
		tt = ((x2 * r) >> 30) / 12;
		r = (tt >= ONE_Q30) ? 64'd0 : ONE_Q30 - tt;
		c = ONE_Q30 - longint'(((x2 * r) >> 30) / 2);
		if (neg) c = -c;
		diff = ONE_Q30 - c;
		if (diff < 0) diff = 0;
		v = (diff + 32768) >>> 16;
		if (v > 32768) v = 32768;
		return 16'(v);
	endfunction

endpackage

>>> design/veg_cosine.sv
// veg_cosine: raised-cosine level lookup, phase multiply then registered ROM read.
// Depends on veg_pkg (rc_level, PHASE_BITS).
module veg_cosine #(
	parameter int COSINE_TABLE_DEPTH = 256
) (
	input  logic        clk,
	input  logic        en,
	input  logic [19:0] freq,
	input  logic [19:0] tim,
	output logic [15:0] level
);
	import veg_pkg::*;

	localparam int IDX_W  = $clog2(COSINE_TABLE_DEPTH);
	localparam int PROD_W = PHASE_BITS + IDX_W;

	logic [15:0]           cos_rom [COSINE_TABLE_DEPTH];
	logic [PHASE_BITS-1:0] phase_s2;
	logic [15:0]           level_s3;
	logic [39:0]           prod;
	// phase scaled by the table depth; the table index sits above the phase bits
	logic [PROD_W-1:0]     scaled;

	for (genvar g = 0; g < COSINE_TABLE_DEPTH; g++) begin : g_rom
		localparam longint THETA = (longint'(g) * TWO_PI_Q30) / COSINE_TABLE_DEPTH;
		assign cos_rom[g] = rc_level(THETA);
	end

	assign prod   = 40'(freq) * 40'(tim);
	assign scaled = PROD_W'(phase_s2) * PROD_W'(COSINE_TABLE_DEPTH);

	always_ff @(posedge clk) begin
		if (en) begin
			phase_s2 <= prod[PHASE_BITS-1:0];
			level_s3 <= cos_rom[scaled[PHASE_BITS +: IDX_W]];
		end
	end

	assign level = level_s3;
endmodule

>>> design/veg_divider.sv
// veg_divider: fully pipelined restoring divider, one quotient bit per stage.
// Depends on veg_pkg (NUM_W, DIV_W, veg_tag_t).
module veg_divider (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_vld,
	input  logic [veg_pkg::NUM_W-1:0] num,
	input  logic [veg_pkg::DIV_W-1:0] den,
	input  veg_pkg::veg_tag_t         tag,
	output logic                      out_vld,
	output logic [veg_pkg::NUM_W-1:0] quot,
	output logic [veg_pkg::DIV_W-1:0] rem,
	output veg_pkg::veg_tag_t         tag_out
);
	import veg_pkg::*;

	logic             vld_s [NUM_W+1];
	logic [NUM_W-1:0] num_s [NUM_W+1];
	logic [DIV_W-1:0] rem_s [NUM_W+1];
	logic [DIV_W-1:0] den_s [NUM_W+1];
	veg_tag_t         tag_s [NUM_W+1];

	assign vld_s[0] = in_vld;
	assign num_s[0] = num;
	assign rem_s[0] = '0;
	assign den_s[0] = den;
	assign tag_s[0] = tag;

	for (genvar g = 0; g < NUM_W; g++) begin : g_stage
		logic [DIV_W:0] trial;
		logic [DIV_W:0] diff;
		logic           fits;

		assign trial = {rem_s[g], num_s[g][NUM_W-1]};
		assign diff  = trial - {1'b0, den_s[g]};
		assign fits  = trial >= {1'b0, den_s[g]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else if (en) begin
				vld_s[g+1] <= vld_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g+1] <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
				num_s[g+1] <= {num_s[g][NUM_W-2:0], fits};
				den_s[g+1] <= den_s[g];
				tag_s[g+1] <= tag_s[g];
			end
		end
	end

	assign out_vld = vld_s[NUM_W];
	assign quot    = num_s[NUM_W];
	assign rem     = rem_s[NUM_W];
	assign tag_out = tag_s[NUM_W];
endmodule

>>> design/vibration_envelope_generator.sv
// vibration_envelope_generator: top level, APB registers, stage control, result select.
// Depends on veg_pkg, veg_cosine, veg_divider.
//
// Usage:
//   Input channel (in_valid/in_ready) carries elapsed_time and effect_length;
//   output channel (out_valid/out_ready) returns intensity (Q1.15) and status.
//   Every input transaction yields exactly one output transaction, in order.
//   The path runs through the input register, phase multiply, cosine ROM read and
//   divider setup, 40 restoring divider stages and the output register.
//   Without receiver stalls, throughput is one transaction per cycle; the 40-stage
//   divider (pulse remainder and fade ratios) and the cosine ROM are fully pipelined.
//   When the receiver stalls with a result waiting, the whole pipeline holds;
//   in_ready drops in the same cycle and nothing is lost or repeated.
//   Reset clears all valid bits and the configuration registers to zero
//   (constant waveform). Registers sit on an APB port at byte addresses 0, 4
//   and 8 and must only be written while no transaction is in flight.
module vibration_envelope_generator #(
	parameter int TIME_BITS          = 24,
	parameter int COSINE_TABLE_DEPTH = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	// APB configuration
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	// input channel
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [23:0]        elapsed_time,
	input  logic signed [24:0] effect_length,
	// output channel
	output logic               out_valid,
	input  logic               out_ready,
	output logic [15:0]        intensity,
	output logic [1:0]         status
);
	import veg_pkg::*;

	// signed width that holds both effect_length and elapsed time, plus a sign
	localparam int R_W = ((TIME_BITS > 24) ? TIME_BITS : 24) + 2;

	// configuration
	logic [2:0]  wave_q;
	logic [23:0] param_a_q;
	logic [23:0] param_b_q;
	logic        wr;

	// pipeline control
	logic en;
	logic v_s1, v_s2, v_s3;
	logic [TIME_BITS-1:0]   t_s1, t_s2;
	logic signed [24:0]     len_s1, len_s2;

	// divider setup (stage 3)
	logic [NUM_W-1:0] num_s3;
	logic [DIV_W-1:0] den_s3;
	veg_tag_t         tag_s3;
	logic [NUM_W-1:0] num_c;
	logic [DIV_W-1:0] den_c;
	veg_tag_t         tag_c;
	veg_tag_t         div_tag;
	veg_tag_t         tag_in;
	logic [15:0]      cos_level;

	logic [DIV_W-1:0]     period;
	logic signed [R_W-1:0] rem_time;
	logic signed [R_W-1:0] a_ext;

	// divider output
	logic             div_vld;
	logic [NUM_W-1:0] div_quot;
	logic [DIV_W-1:0] div_rem;
	logic [15:0]      level_c;

	// output register
	logic        out_v_q;
	logic [15:0] inten_q;
	logic [1:0]  status_q;

	//--------------------------------------------------------------------
	// APB registers: write on the access phase, zero-wait reads
	//--------------------------------------------------------------------
	assign pready = 1'b1;
	assign wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_q    <= WAVE_CONST;
			param_a_q <= '0;
			param_b_q <= '0;
		end else if (wr) begin
			case (paddr[3:2])
				REG_TYPE:    wave_q    <= pwdata[2:0];
				REG_PARAM_A: param_a_q <= pwdata[23:0];
				REG_PARAM_B: param_b_q <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_TYPE:    prdata = {29'd0, wave_q};
			REG_PARAM_A: prdata = {8'd0, param_a_q};
			REG_PARAM_B: prdata = {8'd0, param_b_q};
			default:     prdata = '0;
		endcase
	end

	//--------------------------------------------------------------------
	// Global stall: all stages advance together unless a result waits
	//--------------------------------------------------------------------
	assign en       = !out_v_q || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1   <= TIME_BITS'(elapsed_time);
			len_s1 <= effect_length;
			t_s2   <= t_s1;
			len_s2 <= len_s1;
			num_s3 <= num_c;
			den_s3 <= den_c;
			tag_s3 <= tag_c;
		end
	end

	// phase multiply in stage 2, ROM read lands with stage 3
	veg_cosine #(
		.COSINE_TABLE_DEPTH(COSINE_TABLE_DEPTH)
	) u_cosine (
		.clk   (clk),
		.en    (en),
		.freq  (param_a_q[19:0]),
		.tim   (20'(t_s1)),
		.level (cos_level)
	);

	//--------------------------------------------------------------------
	// Waveform decode and divider setup (stage 2 -> 3)
	//   pulse:  t / (a + b), remainder compared with on-time
	//   fades:  (x * 32768 + a/2) / a, quotient is the level
	//--------------------------------------------------------------------
	assign period   = {1'b0, param_a_q} + {1'b0, param_b_q};
	assign rem_time = R_W'(len_s2) - $signed(R_W'(t_s2));
	assign a_ext    = $signed({{(R_W-24){1'b0}}, param_a_q});

	always_comb begin
		num_c       = '0;
		den_c       = {1'b0, param_a_q};
		tag_c.sel   = SEL_ZERO;
		tag_c.status = ST_OK;
		tag_c.level = '0;
		case (wave_q)
			WAVE_CONST: tag_c.sel = SEL_FULL;
			WAVE_PULSE: begin
				if (period == '0) begin
					tag_c.status = ST_ZERO_LEN;
				end else begin
					tag_c.sel = SEL_PULSE;
					num_c     = NUM_W'(t_s2);
					den_c     = period;
				end
			end
			WAVE_COS: tag_c.sel = SEL_COS;
			WAVE_FADEOUT: begin
				if (len_s2 < 0) begin
					tag_c.status = ST_ENDLESS;
				end else if (rem_time <= a_ext) begin
					if (param_a_q == '0) begin
						tag_c.status = ST_ZERO_LEN;
					end else if (rem_time > 0) begin
						tag_c.sel = SEL_QUOT;
						num_c = NUM_W'({rem_time[23:0], 15'd0}) + NUM_W'(param_a_q[23:1]);
					end
				end else begin
					tag_c.sel = SEL_FULL;
				end
			end
			WAVE_FADEIN: begin
				if (len_s2 < 0) begin
					tag_c.status = ST_ENDLESS;
				end else if (NUM_W'(t_s2) < NUM_W'(param_a_q)) begin
					tag_c.sel = SEL_QUOT;
					num_c = NUM_W'({t_s2, 15'd0}) + NUM_W'(param_a_q[23:1]);
				end else begin
					tag_c.sel = SEL_FULL;
				end
			end
			default: tag_c.status = ST_BAD_TYPE;
		endcase
	end

	// cosine level joins the sideband once the ROM read is back
	always_comb begin
		tag_in       = tag_s3;
		tag_in.level = cos_level;
	end

	veg_divider u_divider (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (v_s3),
		.num     (num_s3),
		.den     (den_s3),
		.tag     (tag_in),
		.out_vld (div_vld),
		.quot    (div_quot),
		.rem     (div_rem),
		.tag_out (div_tag)
	);

	//--------------------------------------------------------------------
	// Result select and output register
	//--------------------------------------------------------------------
	always_comb begin
		case (div_tag.sel)
			SEL_FULL:  level_c = FULL_Q15;
			SEL_COS:   level_c = div_tag.level;
			SEL_QUOT:  level_c = div_quot[15:0];
			SEL_PULSE: level_c = (div_rem < {1'b0, param_a_q}) ? FULL_Q15 : 16'd0;
			default:   level_c = 16'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= div_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			inten_q  <= level_c;
			status_q <= div_tag.status;
		end
	end

	assign out_valid = out_v_q;
	assign intensity = inten_q;
	assign status    = status_q;
endmodule

>>> bench/tb_vibration_envelope_generator.sv
// Testbench for vibration_envelope_generator: drives envelope queries over the
// valid/ready channel, programs waveforms over APB and checks every result.
// Depends on veg_pkg and the vibration_envelope_generator RTL.
module tb_vibration_envelope_generator;
	timeunit 1ns;
	timeprecision 1ps;
	import veg_pkg::*;

	localparam int DEPTH      = 256;
	localparam int LATENCY    = 44;
	localparam int CYCLE_LIMIT = 400000;

	logic               clk;
	logic               arst_n;
	logic               psel, penable, pwrite;
	logic [3:0]         paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	logic               in_valid;
	logic               in_ready;
	logic [23:0]        elapsed_time;
	logic signed [24:0] effect_length;
	logic               out_valid;
	logic               out_ready;
	logic [15:0]        intensity;
	logic [1:0]         status;

	typedef struct {
		logic [15:0] level;
		logic [1:0]  code;
	} envelope_t;

	// shadow of the waveform registers
	logic [2:0]  wave_sel;
	logic [23:0] param_a;
	logic [23:0] param_b;

	envelope_t pending_envelopes[$];
	int        errors;
	longint    cycles;
	// receiver stall control: 0 random stalls, 1 always ready
	bit        sink_eager;

	vibration_envelope_generator dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready),
		.elapsed_time(elapsed_time), .effect_length(effect_length),
		.out_valid(out_valid), .out_ready(out_ready),
		.intensity(intensity), .status(status)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run watchdog
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("vibration_envelope_generator verification failed");
				$finish;
			end
		end
	end

	// Raised cosine level: cos in Q30 by nested Taylor terms on the folded
	// quadrant, then (1 - cos) / 2 in Q15 with round half up.
	function automatic logic [15:0] cosine_level(logic [23:0] t);
		longint unsigned phase, k, x2, acc, term;
		longint          theta, c, diff, v;
		longint unsigned divs[7];
		bit              flip;
		divs = '{182, 132, 90, 56, 30, 12, 2};
		phase = (longint'(param_a) * longint'(t)) & ((64'd1 << 20) - 1);
		k = (phase * DEPTH) >> 20;
		theta = longint'((k * 64'd6746518852) / DEPTH);
		flip = 1'b0;
		if (theta > 64'sd3373259426) theta = 2 * 64'sd3373259426 - theta;
		if (theta < 0) theta = 0;
		if (theta > 64'sd1686629713) begin
			theta = 64'sd3373259426 - theta;
			if (theta < 0) theta = 0;
			flip = 1'b1;
		end
		x2 = (longint'(theta) * longint'(theta)) >> 30;
		acc = 64'd1073741824;
		for (int i = 0; i < 6; i++) begin
			term = ((x2 * acc) >> 30) / divs[i];
			acc = (term >= 64'd1073741824) ? 64'd0 : 64'd1073741824 - term;
		end
		c = 64'sd1073741824 - longint'(((x2 * acc) >> 30) / divs[6]);
		if (flip) c = -c;
		diff = 64'sd1073741824 - c;
		if (diff < 0) diff = 0;
		v = (diff + 32768) / 65536;
		if (v > 32768) v = 32768;
		return 16'(v);
	endfunction

	// expected envelope for one query under the current waveform registers
	function automatic envelope_t predict_envelope(logic [23:0] t, logic signed [24:0] len);
		envelope_t     e;
		longint        period, rem;
		longint unsigned lvl;
		e.level = 16'd0;
		e.code = ST_OK;
		case (wave_sel)
			WAVE_CONST: e.level = FULL_Q15;
			WAVE_PULSE: begin
				period = longint'(param_a) + longint'(param_b);
				if (period == 0) e.code = ST_ZERO_LEN;
				else e.level = ((longint'(t) % period) < longint'(param_a)) ? FULL_Q15 : 16'd0;
			end
			WAVE_COS: e.level = cosine_level(t);
			WAVE_FADEOUT: begin
				if (len < 0) e.code = ST_ENDLESS;
				else begin
					rem = longint'(len) - longint'(t);
					if (rem <= longint'(param_a)) begin
						if (param_a == 0) e.code = ST_ZERO_LEN;
						else if (rem > 0) begin
							lvl = (longint'(rem) * 32768 + (param_a >> 1)) / param_a;
							e.level = (lvl > 32768) ? FULL_Q15 : 16'(lvl);
						end
					end else e.level = FULL_Q15;
				end
			end
			WAVE_FADEIN: begin
				if (len < 0) e.code = ST_ENDLESS;
				else if (t < param_a) begin
					lvl = (longint'(t) * 32768 + (param_a >> 1)) / param_a;
					e.level = (lvl > 32768) ? FULL_Q15 : 16'(lvl);
				end else e.level = FULL_Q15;
			end
			default: e.code = ST_BAD_TYPE;
		endcase
		return e;
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55) return 0;
		if (roll < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// APB write, setup then access, then back to idle; pready is tied high
	task automatic write_register(logic [1:0] idx, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_TYPE:    wave_sel = value[2:0];
			REG_PARAM_A: param_a = value[23:0];
			REG_PARAM_B: param_b = value[23:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// stop sending, drain all results, then let the pipeline settle
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_envelopes.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic program_waveform(logic [2:0] w, logic [23:0] a, logic [23:0] b);
		wait_idle();
		write_register(REG_TYPE, {29'd0, w});
		write_register(REG_PARAM_A, {8'd0, a});
		write_register(REG_PARAM_B, {8'd0, b});
	endtask

	// one input transaction; expectation is queued at the accepting edge
	// in_valid stays high when the next transaction follows with no gap
	task automatic send_query(logic [23:0] t, logic signed [24:0] len);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		elapsed_time <= t;
		effect_length <= len;
		do @(posedge clk); while (!in_ready);
		pending_envelopes.push_back(predict_envelope(t, len));
	endtask

	function automatic logic signed [24:0] random_length();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll == 0) return -25'sd1;
		if (roll == 1) return 25'(-$urandom_range(1, 1 << 24));
		return 25'($urandom_range(0, 24'hFFFFFF));
	endfunction

	// receiver: random stalls, checks each accepted result against the oldest prediction
	initial begin
		envelope_t want;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				if (pending_envelopes.size() == 0) begin
					$display("%0t: unexpected result intensity=%0d status=%0d",
						$time, intensity, status);
					errors++;
				end else begin
					want = pending_envelopes.pop_front();
					if (intensity !== want.level) begin
						$display("%0t: intensity expected %0d actual %0d",
							$time, want.level, intensity);
						errors++;
					end
					if (status !== want.code) begin
						$display("%0t: status expected %0d actual %0d",
							$time, want.code, status);
						errors++;
					end
				end
			end
			out_ready <= sink_eager ? 1'b1 : (pick_gap() == 0);
		end
	end

	// Directed: constant and invalid types, endless lengths, field extremes.
	task automatic test_constant_and_invalid();
		program_waveform(WAVE_CONST, 24'd0, 24'd0);
		send_query(24'd0, 25'sd0);
		send_query(24'hFFFFFF, -25'sd1);
		send_query(24'h555555, 25'sd16777215);
		program_waveform(3'd5, 24'hFFFFFF, 24'hFFFFFF);
		send_query(24'hAAAAAA, -25'sd16777216);
		program_waveform(3'd6, 24'd1, 24'd1);
		send_query(24'd1, 25'sd1);
		program_waveform(3'd7, 24'd0, 24'd0);
		send_query(24'd77, 25'sd0);
	endtask

	// Directed: pulse including zero period and extreme on/off times.
	task automatic test_pulse();
		program_waveform(WAVE_PULSE, 24'd0, 24'd0);
		send_query(24'd5, 25'sd10);
		program_waveform(WAVE_PULSE, 24'd3, 24'd5);
		for (int i = 0; i < 9; i++) send_query(24'(i), -25'sd1);
		program_waveform(WAVE_PULSE, 24'hFFFFFF, 24'hFFFFFF);
		send_query(24'hFFFFFF, 25'sd0);
		send_query(24'hFFFFFE, 25'sd0);
	endtask

	// Directed: fades, endless, zero length inside and outside the window.
	task automatic test_fades();
		program_waveform(WAVE_FADEOUT, 24'd0, 24'd0);
		send_query(24'd10, 25'sd10);
		send_query(24'd20, 25'sd10);
		send_query(24'd5, 25'sd10);
		send_query(24'd5, -25'sd1);
		program_waveform(WAVE_FADEOUT, 24'd1000, 24'd0);
		send_query(24'd500, 25'sd1200);
		send_query(24'hFFFFFF, 25'sd16777215);
		program_waveform(WAVE_FADEIN, 24'd0, 24'd0);
		send_query(24'd0, 25'sd5);
		program_waveform(WAVE_FADEIN, 24'hFFFFFF, 24'd0);
		send_query(24'd3, 25'sd0);
		send_query(24'hFFFFFE, 25'sd100);
		send_query(24'd3, -25'sd16777216);
	endtask

	task automatic test_cosine();
		program_waveform(WAVE_COS, 24'd4096, 24'd0);
		for (int i = 0; i < 8; i++) send_query(24'(i * 32), 25'sd0);
		program_waveform(WAVE_COS, 24'hFFFFFF, 24'd0);
		send_query(24'hFFFFFF, -25'sd1);
	endtask

	// Random phases: types cycle in order, then two random; new random parameters each.
	task automatic test_random_mix();
		logic [2:0]  w;
		logic [23:0] a, b, t;
		for (int p = 0; p < 12; p++) begin
			w = (p < 10) ? 3'(p % 5) : 3'($urandom_range(0, 7));
			a = ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 4000));
			b = ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 4000));
			if (p == 11) a = 24'd0;
			program_waveform(w, a, b);
			sink_eager = (p % 4 == 3);
			for (int i = 0; i < 32; i++) begin
				t = ($urandom_range(0, 1) == 0) ? 24'($urandom) : 24'($urandom_range(0, 8000));
				send_query(t, random_length());
			end
		end
		sink_eager = 1'b0;
	endtask

	initial begin
		errors = 0;
		sink_eager = 1'b0;
		wave_sel = WAVE_CONST;
		param_a = '0;
		param_b = '0;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		in_valid <= 1'b0;
		elapsed_time <= '0;
		effect_length <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// reset setting is the constant waveform
		send_query(24'd123, 25'sd0);
		test_constant_and_invalid();
		test_pulse();
		test_fades();
		test_cosine();
		test_random_mix();
		wait_idle();
		if (errors == 0)
			$display("vibration_envelope_generator verification clean");
		else
			$display("vibration_envelope_generator verification failed");
		$finish;
	end
endmodule
